// ----- hdl/apt_pkg.sv -----
// ----------------------------------------------------------------------------
// apt_pkg - shared types and constants for the affine point transform
// Field widths, pipeline sizing, register indexes and stage control struct.
// ----------------------------------------------------------------------------
package apt_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int COEF_W  = 16;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int PROD_W  = COEF_W + COORD_W;
    // three 48-bit products plus rounding fit easily in 50 bits
    localparam int SUM_W   = PROD_W + 2;

    localparam int NUM_LANES = 3;
    localparam int POINT_W   = NUM_LANES * COORD_W;

    localparam int COEF_FRAC_BITS_DEF = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_ROW_X = 3'd0,
        REG_COEF_ROW_Y = 3'd1,
        REG_COEF_ROW_Z = 3'd2,
        REG_SHIFT_X    = 3'd3,
        REG_SHIFT_Y    = 3'd4,
        REG_SHIFT_Z    = 3'd5
    } cfg_reg_t;

    // Identity matrix at reset
    localparam logic [ROW_W-1:0] COEF_ROW_X_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] COEF_ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] COEF_ROW_Z_RST = 48'h1000_0000_0000;
    localparam logic [COORD_W-1:0] SHIFT_RST    = 32'h0000_0000;

    // Per-stage load enables shared by all lanes
    typedef struct packed {
        logic mul;
        logic sum;
        logic sat;
    } stage_adv_t;

endpackage

// ----- hdl/apt_lane.sv -----
// ----------------------------------------------------------------------------
// apt_lane - one matrix row of the affine transform
// Three products, exact sum with rounding, shift, translation and saturation.
// ----------------------------------------------------------------------------
module apt_lane #(
    parameter int COEF_FRAC_BITS = apt_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  apt_pkg::stage_adv_t                 adv,
    input  logic [apt_pkg::ROW_W-1:0]           coef_row,
    input  logic signed [apt_pkg::COORD_W-1:0]  shift,
    input  logic [apt_pkg::POINT_W-1:0]         point,
    output logic signed [apt_pkg::COORD_W-1:0]  result,
    output logic                                clip
);

    localparam int SUM_W  = apt_pkg::SUM_W;
    localparam int PROD_W = apt_pkg::PROD_W;
    localparam int COEF_W = apt_pkg::COEF_W;
    localparam int COORD_W = apt_pkg::COORD_W;

    localparam logic signed [SUM_W-1:0] ROUND  = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (COORD_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (COORD_W - 1));

    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  total;
    logic signed [COORD_W-1:0] result_reg;
    logic signed [COORD_W-1:0] result_next;
    logic                      clip_reg;
    logic                      clip_next;

    // Multiply each coefficient by its coordinate
    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= $signed(coef_row[c*COEF_W +: COEF_W])
                             * $signed(point[c*COORD_W +: COORD_W]);
            end
        end
    end

    // Sum products exactly and add the rounding half
    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) + ROUND;

    always_ff @(posedge clk)
    begin
        if (adv.sum)
        begin
            sum_reg <= sum_next;
        end
    end

    // Drop fraction bits, translate and saturate
    assign total = (sum_reg >>> COEF_FRAC_BITS) + SUM_W'(shift);

    always_comb
    begin
        if (total > SAT_HI)
        begin
            result_next = SAT_HI[COORD_W-1:0];
            clip_next   = 1'b1;
        end
        else if (total < SAT_LO)
        begin
            result_next = SAT_LO[COORD_W-1:0];
            clip_next   = 1'b1;
        end
        else
        begin
            result_next = total[COORD_W-1:0];
            clip_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.sat)
        begin
            result_reg <= result_next;
            clip_reg   <= clip_next;
        end
    end

    assign result = result_reg;
    assign clip   = clip_reg;

endmodule

// ----- hdl/apt_merge.sv -----
// ----------------------------------------------------------------------------
// apt_merge - output stage of the affine transform
// Packs the lane results into one item and folds the saturation flags.
// ----------------------------------------------------------------------------
module apt_merge (
    input  logic                                      clk,
    input  logic                                      load,
    input  logic [apt_pkg::NUM_LANES*apt_pkg::COORD_W-1:0] lane_result,
    input  logic [apt_pkg::NUM_LANES-1:0]             lane_clip,
    output logic [apt_pkg::POINT_W-1:0]               data,
    output logic                                      clipped
);

    logic [apt_pkg::POINT_W-1:0] data_reg;
    logic                        clipped_reg;
    logic                        clipped_next;

    // Any saturated lane marks the whole item
    assign clipped_next = |lane_clip;

    // Hold the item until the sink takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg    <= lane_result;
            clipped_reg <= clipped_next;
        end
    end

    assign data    = data_reg;
    assign clipped = clipped_reg;

endmodule

// ----- hdl/affine_point_transform_core.sv -----
// ----------------------------------------------------------------------------
// affine_point_transform_core - 3x4 affine transform of Q16.16 points
// One point in, the matrix-transformed and translated point out.
//
//   channel  | dir | data
//   ---------+-----+---------------------------------------------------------
//   s_axis   | in  | s_tdata: point_x, point_y, point_z
//   m_axis   | out | m_tdata: result_x, result_y, result_z; m_tuser: clipped
//   cfg      | in  | cfg_index, cfg_data (register write)
//
// One item per cycle sustained while m_tready is high; from accept to m_tvalid an item passes
// through the multiply, sum, saturate and output register stages.
// Each stage holds its own valid bit, so bubbles close up under a stalled
// output and new items are taken while a result waits.
// Reset clears the valid bits and loads the identity matrix, zero shift.
// cfg_ready is always high; writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module affine_point_transform_core #(
    parameter int COEF_FRAC_BITS = apt_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [apt_pkg::POINT_W-1:0]       s_tdata,   // point_x, point_y, point_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [apt_pkg::POINT_W-1:0]       m_tdata,   // result_x, result_y, result_z
    output logic [0:0]                        m_tuser,   // clipped
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [apt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NL      = apt_pkg::NUM_LANES;
    localparam int COORD_W = apt_pkg::COORD_W;

    logic [apt_pkg::ROW_W-1:0]   coef_row_reg [NL];
    logic [COORD_W-1:0]          shift_reg    [NL];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic adv1, adv2, adv3, adv4;
    logic free1, free2, free3;

    apt_pkg::stage_adv_t          adv;
    logic [NL*COORD_W-1:0]        lane_result;
    logic [NL-1:0]                lane_clip;
    logic                         clipped;

    // Register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_row_reg[0] <= apt_pkg::COEF_ROW_X_RST;
            coef_row_reg[1] <= apt_pkg::COEF_ROW_Y_RST;
            coef_row_reg[2] <= apt_pkg::COEF_ROW_Z_RST;
            shift_reg[0]    <= apt_pkg::SHIFT_RST;
            shift_reg[1]    <= apt_pkg::SHIFT_RST;
            shift_reg[2]    <= apt_pkg::SHIFT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (apt_pkg::cfg_reg_t'(cfg_index))
                apt_pkg::REG_COEF_ROW_X: coef_row_reg[0] <= cfg_data;
                apt_pkg::REG_COEF_ROW_Y: coef_row_reg[1] <= cfg_data;
                apt_pkg::REG_COEF_ROW_Z: coef_row_reg[2] <= cfg_data;
                apt_pkg::REG_SHIFT_X:    shift_reg[0] <= cfg_data[COORD_W-1:0];
                apt_pkg::REG_SHIFT_Y:    shift_reg[1] <= cfg_data[COORD_W-1:0];
                apt_pkg::REG_SHIFT_Z:    shift_reg[2] <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when its source is valid and its slot frees
    assign adv4  = v3_reg && (!v4_reg || m_tready);
    assign free3 = !v3_reg || adv4;
    assign adv3  = v2_reg && free3;
    assign free2 = !v2_reg || adv3;
    assign adv2  = v1_reg && free2;
    assign free1 = !v1_reg || adv2;
    assign adv1  = s_tvalid && free1;

    assign s_tready = free1;

    assign v1_next = adv1 ? 1'b1 : (adv2 ? 1'b0 : v1_reg);
    assign v2_next = adv2 ? 1'b1 : (adv3 ? 1'b0 : v2_reg);
    assign v3_next = adv3 ? 1'b1 : (adv4 ? 1'b0 : v3_reg);
    assign v4_next = adv4 ? 1'b1 : (m_tready ? 1'b0 : v4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign adv.mul = adv1;
    assign adv.sum = adv2;
    assign adv.sat = adv3;

    // One lane per matrix row
    for (genvar r = 0; r < NL; r++)
    begin : g_lane
        apt_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .adv      (adv),
            .coef_row (coef_row_reg[r]),
            .shift    ($signed(shift_reg[r])),
            .point    (s_tdata),
            .result   (lane_result[r*COORD_W +: COORD_W]),
            .clip     (lane_clip[r])
        );
    end

    // Merge lanes into the output item
    apt_merge u_merge (
        .clk         (clk),
        .load        (adv4),
        .lane_result (lane_result),
        .lane_clip   (lane_clip),
        .data        (m_tdata),
        .clipped     (clipped)
    );

    assign m_tvalid   = v4_reg;
    assign m_tuser[0] = clipped;

`ifndef NO_ASSERTIONS
    // An accepted item always occupies the first stage next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        adv1 |=> v1_reg)
        else $error("accepted item not held in multiply stage");

    // A saturate-stage item blocked by the output is never lost
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !adv4) |=> v3_reg)
        else $error("stalled item dropped from saturate stage");

    // The clip flag implies at least one coordinate sits at a limit
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[31:0]  == 32'h7fffffff || m_tdata[31:0]  == 32'h80000000 ||
             m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
             m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000))
        else $error("clipped set without a saturated coordinate");
`endif

endmodule
